// ===== design/lbfs_pkg.sv =====
// Shared types, codes and step tables for the LED and buzzer feedback sequencer.
// Used by lbfs_update, the top level and the port checker; depends on nothing else.
package lbfs_pkg;

  // LED level width and full-scale value
  localparam int LEVEL_BITS    = 12;
  localparam int LEVEL_MAX_INT = (1 << LEVEL_BITS) - 1;
  localparam int ORANGE_G_INT  = LEVEL_MAX_INT / 4 + LEVEL_MAX_INT / 2;

  typedef logic [LEVEL_BITS-1:0] level_t;

  localparam level_t LEVEL_MAX = LEVEL_BITS'(LEVEL_MAX_INT);
  localparam level_t ORANGE_G  = LEVEL_BITS'(ORANGE_G_INT);

  // Command kinds
  typedef enum logic [2:0] {
    KIND_TICK        = 3'd0,
    KIND_SET_COLOR   = 3'd1,
    KIND_SET_RGB     = 3'd2,
    KIND_PLAY_SOUND  = 3'd3,
    KIND_STOP_SOUND  = 3'd4,
    KIND_TRIGGER_PAT = 3'd5,
    KIND_STOP_PAT    = 3'd6
  } kind_t;

  // Named colors
  localparam logic [3:0] COLOR_OFF     = 4'd0;
  localparam logic [3:0] COLOR_RED     = 4'd1;
  localparam logic [3:0] COLOR_GREEN   = 4'd2;
  localparam logic [3:0] COLOR_BLUE    = 4'd3;
  localparam logic [3:0] COLOR_YELLOW  = 4'd4;
  localparam logic [3:0] COLOR_CYAN    = 4'd5;
  localparam logic [3:0] COLOR_MAGENTA = 4'd6;
  localparam logic [3:0] COLOR_WHITE   = 4'd7;
  localparam logic [3:0] COLOR_ORANGE  = 4'd8;
  localparam logic [3:0] COLOR_CUSTOM  = 4'd9;

  // Sound and pattern ids
  localparam logic [2:0] SND_NONE    = 3'd0;
  localparam logic [2:0] SND_STARTUP = 3'd2;
  localparam logic [2:0] SND_SUCCESS = 3'd3;
  localparam logic [2:0] SND_ERROR   = 3'd4;
  localparam logic [2:0] SND_WARNING = 3'd5;
  localparam logic [2:0] SND_NOTIFY  = 3'd6;
  localparam logic [2:0] SND_LAST    = 3'd6;
  localparam logic [2:0] PAT_NONE    = 3'd0;
  localparam logic [2:0] PAT_LAST    = 3'd5;

  typedef struct packed {
    level_t r;
    level_t g;
    level_t b;
  } rgb_t;

  typedef struct packed {
    logic [2:0]  id;
    logic [1:0]  step;
    logic [31:0] deadline;
    logic [15:0] period;
    logic [15:0] cmp;
    logic        flag;
  } snd_t;

  typedef struct packed {
    logic [2:0]  id;
    logic [1:0]  step;
    logic [31:0] deadline;
  } pat_t;

  typedef struct packed {
    rgb_t shown;
    rgb_t custom;
    snd_t snd;
    pat_t pat;
  } state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] now_ms;
    logic [3:0]  color;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [2:0]  sound_id;
    logic [2:0]  pattern_id;
  } cmd_t;

  // Number of steps in each tone sequence
  function automatic logic [1:0] tone_len(logic [2:0] s);
    case (s)
      3'd1:    return 2'd1;
      3'd2:    return 2'd3;
      3'd3:    return 2'd2;
      3'd4:    return 2'd2;
      3'd5:    return 2'd3;
      3'd6:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  // 3 MHz timer counts per tone step (3000000 / frequency), zero for a rest
  function automatic logic [15:0] tone_counts(logic [2:0] s, logic [1:0] i);
    case ({s, i})
      {3'd1, 2'd0}: return 16'd1250;   // 2400 Hz
      {3'd2, 2'd0}: return 16'd5736;   // 523 Hz
      {3'd2, 2'd1}: return 16'd4552;   // 659 Hz
      {3'd2, 2'd2}: return 16'd3826;   // 784 Hz
      {3'd3, 2'd0}: return 16'd3409;   // 880 Hz
      {3'd3, 2'd1}: return 16'd2553;   // 1175 Hz
      {3'd4, 2'd0}: return 16'd9090;   // 330 Hz
      {3'd4, 2'd1}: return 16'd13636;  // 220 Hz
      {3'd5, 2'd0}: return 16'd3036;   // 988 Hz
      {3'd5, 2'd2}: return 16'd3036;   // 988 Hz
      {3'd6, 2'd0}: return 16'd2274;   // 1319 Hz
      {3'd6, 2'd1}: return 16'd1913;   // 1568 Hz
      default:      return 16'd0;
    endcase
  endfunction

  // Tone step durations in ms
  function automatic logic [7:0] tone_dur(logic [2:0] s, logic [1:0] i);
    case ({s, i})
      {3'd1, 2'd0}: return 8'd80;
      {3'd2, 2'd0}: return 8'd80;
      {3'd2, 2'd1}: return 8'd80;
      {3'd2, 2'd2}: return 8'd120;
      {3'd3, 2'd0}: return 8'd70;
      {3'd3, 2'd1}: return 8'd120;
      {3'd4, 2'd0}: return 8'd140;
      {3'd4, 2'd1}: return 8'd220;
      {3'd5, 2'd0}: return 8'd90;
      {3'd5, 2'd1}: return 8'd60;
      {3'd5, 2'd2}: return 8'd90;
      {3'd6, 2'd0}: return 8'd60;
      {3'd6, 2'd1}: return 8'd60;
      default:      return 8'd0;
    endcase
  endfunction

  // Number of steps in each light pattern
  function automatic logic [1:0] pat_len(logic [2:0] p);
    case (p)
      3'd1:    return 2'd2;
      3'd2:    return 2'd1;
      3'd3:    return 2'd3;
      3'd4:    return 2'd3;
      3'd5:    return 2'd1;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [3:0] pat_color(logic [2:0] p, logic [1:0] i);
    case ({p, i})
      {3'd1, 2'd0}: return COLOR_BLUE;
      {3'd1, 2'd1}: return COLOR_GREEN;
      {3'd2, 2'd0}: return COLOR_GREEN;
      {3'd3, 2'd0}: return COLOR_RED;
      {3'd3, 2'd2}: return COLOR_RED;
      {3'd4, 2'd0}: return COLOR_ORANGE;
      {3'd4, 2'd2}: return COLOR_ORANGE;
      {3'd5, 2'd0}: return COLOR_CYAN;
      default:      return COLOR_OFF;
    endcase
  endfunction

  function automatic logic [2:0] pat_sound(logic [2:0] p, logic [1:0] i);
    case ({p, i})
      {3'd1, 2'd0}: return SND_STARTUP;
      {3'd2, 2'd0}: return SND_SUCCESS;
      {3'd3, 2'd0}: return SND_ERROR;
      {3'd4, 2'd0}: return SND_WARNING;
      {3'd5, 2'd0}: return SND_NOTIFY;
      default:      return SND_NONE;
    endcase
  endfunction

  // Pattern step durations in ms
  function automatic logic [8:0] pat_dur(logic [2:0] p, logic [1:0] i);
    case ({p, i})
      {3'd1, 2'd0}: return 9'd320;
      {3'd1, 2'd1}: return 9'd220;
      {3'd2, 2'd0}: return 9'd240;
      {3'd3, 2'd0}: return 9'd260;
      {3'd3, 2'd1}: return 9'd80;
      {3'd3, 2'd2}: return 9'd180;
      {3'd4, 2'd0}: return 9'd180;
      {3'd4, 2'd1}: return 9'd80;
      {3'd4, 2'd2}: return 9'd180;
      {3'd5, 2'd0}: return 9'd180;
      default:      return 9'd0;
    endcase
  endfunction

endpackage

// ===== design/lbfs_update.sv =====
// Next-state logic of the sequencer: applies one command to the current state.
// Purely combinational; depends on lbfs_pkg for types and step tables.
module lbfs_update
  import lbfs_pkg::*;
(
  input  state_t cur,
  input  cmd_t   cmd,
  input  logic   muted,
  output state_t nxt
);

  // Deadline reached when (now - deadline) mod 2^32 is not negative
  function automatic logic deadline_hit(logic [31:0] now, logic [31:0] dl);
    logic [31:0] diff;
    diff = now - dl;
    return !diff[31];
  endfunction

  function automatic level_t clamp_level(logic [15:0] v);
    if (v > 16'(LEVEL_MAX_INT)) begin
      return LEVEL_MAX;
    end
    return v[LEVEL_BITS-1:0];
  endfunction

  function automatic rgb_t show_color(logic [3:0] color, rgb_t custom);
    rgb_t c;
    c = '0;
    case (color)
      COLOR_RED:     c.r = LEVEL_MAX;
      COLOR_GREEN:   c.g = LEVEL_MAX;
      COLOR_BLUE:    c.b = LEVEL_MAX;
      COLOR_YELLOW:  begin c.r = LEVEL_MAX; c.g = LEVEL_MAX; end
      COLOR_CYAN:    begin c.g = LEVEL_MAX; c.b = LEVEL_MAX; end
      COLOR_MAGENTA: begin c.r = LEVEL_MAX; c.b = LEVEL_MAX; end
      COLOR_WHITE:   begin c.r = LEVEL_MAX; c.g = LEVEL_MAX; c.b = LEVEL_MAX; end
      COLOR_ORANGE:  begin c.r = LEVEL_MAX; c.g = ORANGE_G; end
      COLOR_CUSTOM:  c = custom;
      default:       c = '0;
    endcase
    return c;
  endfunction

  // Load buzzer timer; a mute or a rest only clears the compare
  function automatic snd_t buzzer_set(snd_t st, logic [15:0] cnt, logic mute);
    snd_t r;
    r = st;
    if (mute || cnt == 16'd0) begin
      r.cmp = 16'd0;
    end else begin
      r.period = cnt - 16'd1;
      r.cmp    = cnt >> 1;
    end
    return r;
  endfunction

  function automatic snd_t snd_stop(snd_t st);
    snd_t r;
    r          = st;
    r.id       = SND_NONE;
    r.step     = 2'd0;
    r.deadline = 32'd0;
    r.flag     = 1'b0;
    r.cmp      = 16'd0;
    return r;
  endfunction

  function automatic snd_t snd_advance(snd_t st, logic [31:0] now, logic mute);
    snd_t        r;
    logic [15:0] cnt;
    r   = st;
    cnt = tone_counts(st.id, st.step);
    if (st.id == SND_NONE || st.id > SND_LAST || st.step >= tone_len(st.id)) begin
      r = snd_stop(st);
    end else begin
      r          = buzzer_set(st, cnt, mute);
      r.flag     = (cnt != 16'd0);
      r.deadline = now + 32'(tone_dur(st.id, st.step));
      r.step     = st.step + 2'd1;
    end
    return r;
  endfunction

  function automatic snd_t snd_play(snd_t st, logic [2:0] id, logic [31:0] now,
                                    logic mute);
    snd_t r;
    r      = st;
    r.id   = id;
    r.step = 2'd0;
    if (mute || id == SND_NONE) begin
      r = snd_stop(st);
    end else begin
      r = snd_advance(r, now, mute);
    end
    return r;
  endfunction

  // One pattern step: show its color, start or stop its sound, rearm deadline; past the last step, clear the pattern
  function automatic state_t pat_advance(state_t st, logic [31:0] now, logic mute);
    state_t     r;
    logic [2:0] p;
    logic [1:0] i;
    logic [2:0] ps;
    r  = st;
    p  = st.pat.id;
    i  = st.pat.step;
    ps = pat_sound(p, i);
    if (p == PAT_NONE || p > PAT_LAST || i >= pat_len(p)) begin
      r.pat = '0;
    end else begin
      r.shown = show_color(pat_color(p, i), st.custom);
      if (ps != SND_NONE) begin
        r.snd = snd_play(st.snd, ps, now, mute);
      end else begin
        r.snd = snd_stop(st.snd);
      end
      r.pat.deadline = now + 32'(pat_dur(p, i));
      r.pat.step     = i + 2'd1;
    end
    return r;
  endfunction

  // Apply the request
  always_comb begin
    nxt = cur;
    case (cmd.kind)
      KIND_TICK: begin
        if (cur.snd.id != SND_NONE && deadline_hit(cmd.now_ms, cur.snd.deadline)) begin
          nxt.snd = snd_advance(cur.snd, cmd.now_ms, muted);
        end
        if (cur.pat.id != PAT_NONE && deadline_hit(cmd.now_ms, cur.pat.deadline)) begin
          nxt = pat_advance(nxt, cmd.now_ms, muted);
        end
      end
      KIND_SET_COLOR: begin
        nxt.pat   = '0;
        nxt.shown = show_color(cmd.color, cur.custom);
      end
      KIND_SET_RGB: begin
        nxt.pat      = '0;
        nxt.custom.r = clamp_level(cmd.red);
        nxt.custom.g = clamp_level(cmd.green);
        nxt.custom.b = clamp_level(cmd.blue);
        nxt.shown    = nxt.custom;
      end
      KIND_PLAY_SOUND: begin
        nxt.snd = snd_play(cur.snd, cmd.sound_id, cmd.now_ms, muted);
      end
      KIND_STOP_SOUND: begin
        nxt.snd = snd_stop(cur.snd);
      end
      KIND_TRIGGER_PAT: begin
        if (cmd.pattern_id == PAT_NONE) begin
          nxt.pat = '0;
        end else begin
          nxt.pat.id   = cmd.pattern_id;
          nxt.pat.step = 2'd0;
          nxt          = pat_advance(nxt, cmd.now_ms, muted);
        end
      end
      KIND_STOP_PAT: begin
        nxt.pat = '0;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// ===== design/led_buzzer_feedback_sequencer_top.sv =====
// Top level of the LED and buzzer feedback sequencer: handshake, state and
// result registers. Depends on lbfs_pkg and lbfs_update.
//
// Usage:
//   Input channel (in_*): one command per request, stamped with the current
//   millisecond time. Kind tick advances a running tone sequence, then a
//   running light pattern, once their deadlines are reached; the other kinds
//   set a color, set custom RGB, play or stop a sound, trigger or stop a
//   pattern. Every request yields exactly one result on out_*.
//   Config port: cfg_wr_en/cfg_wr_data write the buzzer mute bit;
//   write it only while no request is in flight.
//   A request accepted on the input channel is captured in the input register,
//   then processed and loaded into the result register once the result slot is
//   free or draining, and offered on out_* from there. Throughput is one request
//   per cycle while out_ready stays high, set by the single pass through
//   lbfs_update between the two registers.
//   Stall: while out_ready is low the result holds; the input register keeps
//   one more request, and in_ready drops only when both are full.
//   Reset (rst_n low, synchronous): LEDs off, custom color full white, no
//   sound or pattern, buzzer registers zero, unmuted, both channels empty.
module led_buzzer_feedback_sequencer_top
  import lbfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // config
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_kind,
  input  logic [31:0]           in_now_ms,
  input  logic [3:0]            in_color,
  input  logic [15:0]           in_red_in,
  input  logic [15:0]           in_green_in,
  input  logic [15:0]           in_blue_in,
  input  logic [2:0]            in_sound_id,
  input  logic [2:0]            in_pattern_id,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LEVEL_BITS-1:0] out_red_level,
  output logic [LEVEL_BITS-1:0] out_green_level,
  output logic [LEVEL_BITS-1:0] out_blue_level,
  output logic [LEVEL_BITS-1:0] out_red_pwm_compare,
  output logic [LEVEL_BITS-1:0] out_green_pwm_compare,
  output logic [LEVEL_BITS-1:0] out_blue_pwm_compare,
  output logic [15:0]           out_tone_reload,
  output logic [15:0]           out_tone_compare,
  output logic                  out_buzzer_on,
  output logic                  out_light_on,
  output logic                  out_sound_busy,
  output logic                  out_pattern_busy
);

  logic   muted_r;
  logic   in_full_r;
  cmd_t   cmd_r;
  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  rgb_t   res_rgb_r;
  logic   [15:0] res_reload_r;
  logic   [15:0] res_cmp_r;
  logic   res_buz_r;
  logic   res_snd_busy_r;
  logic   res_pat_busy_r;
  logic   advance;

  // Process the held request when the result slot is free or draining
  assign advance  = in_full_r && (!out_valid_r || out_ready);
  assign in_ready = !in_full_r || advance;

  // Mute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      muted_r <= 1'b0;
    end else if (cfg_wr_en) begin
      muted_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_ready) begin
      in_full_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= '{kind: in_kind, now_ms: in_now_ms, color: in_color,
                 red: in_red_in, green: in_green_in, blue: in_blue_in,
                 sound_id: in_sound_id, pattern_id: in_pattern_id};
    end
  end

  lbfs_update u_update (
    .cur   (state_r),
    .cmd   (cmd_r),
    .muted (muted_r),
    .nxt   (state_nxt)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{shown: '0,
                   custom: '{r: LEVEL_MAX, g: LEVEL_MAX, b: LEVEL_MAX},
                   snd: '0, pat: '0};
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      res_rgb_r      <= state_nxt.shown;
      res_reload_r   <= state_nxt.snd.period;
      res_cmp_r      <= state_nxt.snd.cmp;
      res_buz_r      <= state_nxt.snd.flag;
      res_snd_busy_r <= (state_nxt.snd.id != SND_NONE);
      res_pat_busy_r <= (state_nxt.pat.id != PAT_NONE);
    end
  end

  assign out_valid             = out_valid_r;
  assign out_red_level         = res_rgb_r.r;
  assign out_green_level       = res_rgb_r.g;
  assign out_blue_level        = res_rgb_r.b;
  assign out_red_pwm_compare   = LEVEL_MAX - res_rgb_r.r;
  assign out_green_pwm_compare = LEVEL_MAX - res_rgb_r.g;
  assign out_blue_pwm_compare  = LEVEL_MAX - res_rgb_r.b;
  assign out_tone_reload       = res_reload_r;
  assign out_tone_compare      = res_cmp_r;
  assign out_buzzer_on         = res_buz_r;
  assign out_light_on          = (res_rgb_r != '0);
  assign out_sound_busy        = res_snd_busy_r;
  assign out_pattern_busy      = res_pat_busy_r;

endmodule

// ===== design/lbfs_checker.sv =====
// Port-level checks for the LED and buzzer feedback sequencer, bound to the top.
// Depends on lbfs_pkg and led_buzzer_feedback_sequencer_top.
module lbfs_checker
  import lbfs_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [LEVEL_BITS-1:0] out_red_level,
  input logic [LEVEL_BITS-1:0] out_green_level,
  input logic [LEVEL_BITS-1:0] out_blue_level,
  input logic [LEVEL_BITS-1:0] out_red_pwm_compare,
  input logic [15:0]           out_tone_compare,
  input logic                  out_buzzer_on,
  input logic                  out_light_on,
  input logic                  out_sound_busy
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red_level))
    else $error("result dropped or changed while stalled");

  // Drive red common anode as the complement of the level
  a_pwm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_red_pwm_compare == LEVEL_MAX - out_red_level)
    else $error("red pwm compare does not match level");

  // Light flag follows the levels
  a_light: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_light_on == (out_red_level != '0 || out_green_level != '0 ||
                                   out_blue_level != '0))
    else $error("light_on disagrees with levels");

  // A sounding buzzer belongs to a running tone step
  a_buzz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tone_compare != 16'd0 |-> out_buzzer_on && out_sound_busy)
    else $error("buzzer compare set without a running tone");

endmodule

bind led_buzzer_feedback_sequencer_top lbfs_checker u_lbfs_checker (.*);
